// ----- src/rmst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rmst_pkg;

   localparam int LEAF_BITS  = 10;
   localparam int ADDR_W     = LEAF_BITS + 1;
   localparam int LEAF_COUNT = 1 << LEAF_BITS;
   localparam int POS_W      = 11;
   localparam int DATA_W     = 32;
   // wide enough for a field, the leaf count and one carry
   localparam int CALC_W     = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;

   localparam logic [DATA_W-1:0] MIN_IDENTITY = 32'h3f3f3f3f;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY
   } state_type;

   function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
      smin = ($signed(a) <= $signed(b)) ? a : b;
   endfunction

endpackage
`default_nettype wire

// ----- src/range_min_segment_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Range-minimum segment tree over 2^LEAF_BITS signed 32-bit leaves, held in one
// node memory with one write port and two registered read ports. After reset the
// block sweeps the memory to the identity 0x3f3f3f3f, one node a cycle, with busy
// high until every node is written. An item is taken when start is high and busy
// low. An update walks from the leaf to the root, one level a cycle, each step
// writing the new node and reading its sibling; an update outside the leaf range
// does nothing and leaves the block idle. A query issues its first reads when it
// is taken, then climbs one tree level a cycle (two node reads a cycle) until its
// bounds cross, then closes. Its result appears on rsp_range_minimum for one cycle
// with rsp_valid high and must be taken then; the receiver cannot stall the block.
module range_min_segment_tree (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_type,
   input  wire logic [rmst_pkg::POS_W-1:0] req_position,
   input  wire logic signed [31:0]         req_new_value,
   input  wire logic [rmst_pkg::POS_W-1:0] req_left_end,
   input  wire logic [rmst_pkg::POS_W-1:0] req_right_end,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_range_minimum
);

   localparam int ADDR_W = rmst_pkg::ADDR_W;
   localparam int DATA_W = rmst_pkg::DATA_W;
   localparam int CALC_W = rmst_pkg::CALC_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [CALC_W-1:0] LEAF_CNT_C = CALC_W'(rmst_pkg::LEAF_COUNT);
   localparam logic [CALC_W-1:0] ONE_C      = CALC_W'(1);

   rmst_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0] node_ff, node_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic              first_ff, first_in;
   logic [ADDR_W:0]   l_ff, l_in;
   logic [ADDR_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] mem [DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic              accept;
   logic [CALC_W-1:0] pos_c, lo_c, hi_c, hi_raw;
   logic              upd_ok, q_empty;
   logic [CALC_W-1:0] leaf_sum, lo_sum, hi_sum;
   logic              q_run, take_l, take_r;
   logic [DATA_W-1:0] acc_l, acc_lr, upd_val;
   logic [ADDR_W:0]   l_step, l_next;
   logic [ADDR_W-1:0] r_step, r_next;

   assign busy    = (state_ff != rmst_pkg::ST_IDLE);
   assign accept  = start && !busy;

   // operand decode for a new item
   always_comb begin
      pos_c    = CALC_W'(req_position);
      hi_raw   = CALC_W'(req_right_end);
      lo_c     = (req_left_end == '0) ? ONE_C : CALC_W'(req_left_end);
      hi_c     = (hi_raw > LEAF_CNT_C) ? LEAF_CNT_C : hi_raw;
      upd_ok   = (pos_c >= ONE_C) && (pos_c <= LEAF_CNT_C);
      q_empty  = (hi_c == '0) || (lo_c > hi_c);
      leaf_sum = LEAF_CNT_C + pos_c - ONE_C;
      lo_sum   = LEAF_CNT_C + lo_c - ONE_C;
      hi_sum   = LEAF_CNT_C + hi_c - ONE_C;
   end

   // query level step on the node pair just read
   always_comb begin
      q_run  = (l_ff <= {1'b0, r_ff});
      take_l = l_ff[0];
      take_r = !r_ff[0];
      acc_l  = take_l ? rmst_pkg::smin(acc_ff, rd_a_ff) : acc_ff;
      acc_lr = take_r ? rmst_pkg::smin(acc_l, rd_b_ff) : acc_l;
      l_step = l_ff + (ADDR_W+1)'(take_l);
      r_step = r_ff - ADDR_W'(take_r);
      l_next = l_step >> 1;
      r_next = r_step >> 1;
      upd_val = first_ff ? cur_ff : rmst_pkg::smin(cur_ff, rd_a_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            if (node_ff == '0) state_in = rmst_pkg::ST_IDLE;
         end
         rmst_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == rmst_pkg::REQ_QUERY) state_in = rmst_pkg::ST_QUERY;
               else if (upd_ok)                     state_in = rmst_pkg::ST_UPDATE;
            end
         end
         rmst_pkg::ST_UPDATE: begin
            if (node_ff == ADDR_W'(1)) state_in = rmst_pkg::ST_IDLE;
         end
         rmst_pkg::ST_QUERY: begin
            if (!q_run) state_in = rmst_pkg::ST_IDLE;
         end
         default: state_in = rmst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      node_in      = node_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = node_ff;
      mem_wdata    = rmst_pkg::MIN_IDENTITY;
      rd_addr_a    = node_ff ^ ADDR_W'(1);
      rd_addr_b    = r_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            node_in = node_ff - ADDR_W'(1);
         end
         rmst_pkg::ST_IDLE: begin
            node_in  = leaf_sum[ADDR_W-1:0];
            cur_in   = req_new_value;
            first_in = 1'b1;
            acc_in   = rmst_pkg::MIN_IDENTITY;
            if (q_empty) begin
               // force l past r so the walk closes at once
               l_in = (ADDR_W+1)'(1);
               r_in = '0;
            end else begin
               l_in = {1'b0, lo_sum[ADDR_W-1:0]};
               r_in = hi_sum[ADDR_W-1:0];
            end
            rd_addr_a = lo_sum[ADDR_W-1:0];
            rd_addr_b = hi_sum[ADDR_W-1:0];
         end
         rmst_pkg::ST_UPDATE: begin
            // write this level, read its sibling for the next one
            mem_we    = 1'b1;
            mem_wdata = upd_val;
            cur_in    = upd_val;
            first_in  = 1'b0;
            node_in   = node_ff >> 1;
         end
         rmst_pkg::ST_QUERY: begin
            rd_addr_a = l_next[ADDR_W-1:0];
            rd_addr_b = r_next;
            if (q_run) begin
               acc_in = acc_lr;
               l_in   = l_next;
               r_in   = r_next;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         node_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_data_ff;

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == rmst_pkg::ST_QUERY)
      else $error("result word without a finished query");

   a_update_climbs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_UPDATE && node_ff != ADDR_W'(1)) |=>
         (state_ff == rmst_pkg::ST_UPDATE && node_ff == ($past(node_ff) >> 1)))
      else $error("update walk left its path to the root");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_IDLE || state_ff == rmst_pkg::ST_QUERY) |-> !mem_we)
      else $error("node memory written outside clear or update");

   a_update_no_node0: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_UPDATE) |-> node_ff != '0)
      else $error("update reached node zero");

endmodule
`default_nettype wire
